/* hdl/pidpi_pkg.sv */
package pidpi_pkg;

	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 24;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;

	localparam logic [GAIN_W-1:0]  KP_RST    = 16'd256;
	localparam logic [GAIN_W-1:0]  KI_RST    = 16'd0;
	localparam logic [GAIN_W-1:0]  KD_RST    = 16'd7680;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd1000;

	typedef struct packed {
		logic               mode;
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

endpackage

/* hdl/pid_position_incremental_core.sv */
// channel  direction  beat contents
// in       sink       measured, setpoint, clear
// out      source     control_out
// cfg      sink       cfg_index, cfg_data (always ready)
//
// One beat in per cycle while the block is not back-pressured. An accepted beat
// passes through the input register and then the result register, from which
// its result is offered on the out channel.
// Error history and integral are updated as a beat leaves the input register,
// so consecutive beats see each other's state.
// A stalled output holds the result register and back-pressures the input
// register only once both are full. arst_n clears valids and history and loads
// the default mode, gains and limit.
module pid_position_incremental_core
	import pidpi_pkg::*;
#(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [DATA_WIDTH-1:0]  measured,
	input  logic signed [DATA_WIDTH-1:0]  setpoint,
	input  logic                          clear,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [OUT_W-1:0]       control_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int EW = DATA_WIDTH + 1;
	localparam int IW = LIMIT_W + GAIN_FRAC_BITS + 2;

	cfg_t                          cfg_q;
	logic                          valid_s1;
	logic signed [DATA_WIDTH-1:0]  meas_s1, setp_s1;
	logic                          clear_s1;
	logic                          out_valid_q;
	logic signed [OUT_W-1:0]       ctrl_q;
	logic signed [EW-1:0]          e1_q, e2_q;
	logic signed [IW-1:0]          isum_q;

	logic                          out_free, fire_s1;
	logic signed [EW-1:0]          error;
	logic signed [IW-1:0]          isum_next;
	logic signed [OUT_W-1:0]       ctrl_next;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign fire_s1   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_POSITIONAL;
			cfg_q.kp    <= KP_RST;
			cfg_q.ki    <= KI_RST;
			cfg_q.kd    <= KD_RST;
			cfg_q.limit <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:  cfg_q.mode  <= cfg_data[0];
				REG_KP:    cfg_q.kp    <= cfg_data[GAIN_W-1:0];
				REG_KI:    cfg_q.ki    <= cfg_data[GAIN_W-1:0];
				REG_KD:    cfg_q.kd    <= cfg_data[GAIN_W-1:0];
				REG_LIMIT: cfg_q.limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			e1_q        <= '0;
			e2_q        <= '0;
			isum_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				e2_q   <= clear_s1 ? '0 : e1_q;
				e1_q   <= error;
				isum_q <= isum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_s1  <= measured;
			setp_s1  <= setpoint;
			clear_s1 <= clear;
		end
		if (fire_s1) begin
			ctrl_q <= ctrl_next;
		end
	end

	pidpi_calc #(
		.DATA_WIDTH     (DATA_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_calc (
		.measured       (meas_s1),
		.setpoint       (setp_s1),
		.clear          (clear_s1),
		.cfg            (cfg_q),
		.last_error     (e1_q),
		.previous_error (e2_q),
		.integral_sum   (isum_q),
		.error          (error),
		.integral_next  (isum_next),
		.control_out    (ctrl_next)
	);

	assign out_valid   = out_valid_q;
	assign control_out = ctrl_q;

endmodule

/* hdl/pidpi_calc.sv */
module pidpi_calc
	import pidpi_pkg::*;
#(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic signed [DATA_WIDTH-1:0]                 measured,
	input  logic signed [DATA_WIDTH-1:0]                 setpoint,
	input  logic                                         clear,
	input  cfg_t                                         cfg,
	input  logic signed [DATA_WIDTH:0]                   last_error,
	input  logic signed [DATA_WIDTH:0]                   previous_error,
	input  logic signed [LIMIT_W+GAIN_FRAC_BITS+1:0]     integral_sum,
	output logic signed [DATA_WIDTH:0]                   error,
	output logic signed [LIMIT_W+GAIN_FRAC_BITS+1:0]     integral_next,
	output logic signed [OUT_W-1:0]                      control_out
);

	localparam int EW    = DATA_WIDTH + 1;
	localparam int DF_W  = DATA_WIDTH + 3;
	localparam int GS_W  = GAIN_W + 1;
	localparam int PR_W  = GS_W + DF_W;
	localparam int IW    = LIMIT_W + GAIN_FRAC_BITS + 2;
	localparam int PS_W  = ((IW > PR_W) ? IW : PR_W) + 1;
	localparam int SUM_W = ((IW > PR_W) ? IW : PR_W) + 2;
	localparam int ACC_W = (SUM_W > OUT_W + GAIN_FRAC_BITS + 1) ? SUM_W
		: OUT_W + GAIN_FRAC_BITS + 1;

	localparam logic signed [ACC_W-1:0] RND     = ACC_W'((2 ** GAIN_FRAC_BITS) - 1);
	localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'({(OUT_W-1){1'b1}});
	localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

	logic signed [EW-1:0]    e1, e2;
	logic signed [IW-1:0]    isum;
	logic signed [DF_W-1:0]  d1, d2, a_op, c_op;
	logic signed [GS_W-1:0]  kp_s, ki_s, kd_s;
	logic signed [PR_W-1:0]  m_a, m_b, m_c;
	logic signed [PS_W-1:0]  pre, lim, lim_n;
	logic signed [IW-1:0]    clamped;
	logic signed [ACC_W-1:0] acc, acc_adj, res;

	// clear zeroes history before this beat is used
	assign e1   = clear ? '0 : last_error;
	assign e2   = clear ? '0 : previous_error;
	assign isum = clear ? '0 : integral_sum;

	assign error = EW'(setpoint) - EW'(measured);

	assign d1 = DF_W'(error) - DF_W'(e1);
	assign d2 = DF_W'(error) - (DF_W'(e1) <<< 1) + DF_W'(e2);

	assign kp_s = $signed({1'b0, cfg.kp});
	assign ki_s = $signed({1'b0, cfg.ki});
	assign kd_s = $signed({1'b0, cfg.kd});

	// operands shared between modes: three multipliers cover both forms
	assign a_op = (cfg.mode == MODE_INCREMENTAL) ? d1 : DF_W'(error);
	assign c_op = (cfg.mode == MODE_INCREMENTAL) ? d2 : d1;

	assign m_a = kp_s * a_op;
	assign m_b = ki_s * DF_W'(error);
	assign m_c = kd_s * c_op;

	assign pre   = PS_W'(isum) + PS_W'(m_b);
	assign lim   = PS_W'($signed({1'b0, cfg.limit, {GAIN_FRAC_BITS{1'b0}}}));
	assign lim_n = -lim;

	always_comb begin
		priority if (pre >= lim) begin
			clamped = IW'(lim);
		end else if (pre <= lim_n) begin
			clamped = IW'(lim_n);
		end else begin
			clamped = IW'(pre);
		end
	end

	assign integral_next = (cfg.mode == MODE_INCREMENTAL) ? isum : clamped;

	always_comb begin
		if (cfg.mode == MODE_INCREMENTAL) begin
			acc = ACC_W'(m_a) + ACC_W'(m_b) + ACC_W'(m_c);
		end else begin
			acc = ACC_W'(m_a) + ACC_W'(clamped) + ACC_W'(m_c);
		end
	end

	// truncate toward zero
	assign acc_adj = acc[ACC_W-1] ? acc + RND : acc;
	assign res     = acc_adj >>> GAIN_FRAC_BITS;

	always_comb begin
		priority if (res > OUT_MAX) begin
			control_out = OUT_W'(OUT_MAX);
		end else if (res < OUT_MIN) begin
			control_out = OUT_W'(OUT_MIN);
		end else begin
			control_out = OUT_W'(res);
		end
	end

endmodule

/* dv/tb_pid_position_incremental_core.sv */
module tb_pid_position_incremental_core;
	import pidpi_pkg::*;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTINGS_EVERY = 33;
	localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	logic signed [DATA_W-1:0]     measured  = '0;
	logic signed [DATA_W-1:0]     setpoint  = '0;
	logic                         clear     = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic signed [OUT_W-1:0]      control_out;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index = '0;
	logic [CFG_DATA_W-1:0]        cfg_data  = '0;

	// predictor state: register copy, error history, integral with FRAC_BITS fraction bits
	cfg_t                         pid_regs;
	logic signed [DATA_W:0]       err_last;
	logic signed [DATA_W:0]       err_prev;
	logic signed [33:0]           integ_sum;

	logic signed [OUT_W-1:0]      expected_ctrl[$];
	int                           outstanding   = 0;
	int                           errors        = 0;
	int                           src_idle_pct  = 0;
	int                           sink_idle_pct = 0;
	int                           quiet_cycles  = 0;
	logic signed [DATA_W-1:0]     target        = '0;

	pid_position_incremental_core #(
		.DATA_WIDTH     (DATA_W),
		.GAIN_FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.measured    (measured),
		.setpoint    (setpoint),
		.clear       (clear),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.control_out (control_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic signed [OUT_W-1:0] pid_output(
		input logic signed [DATA_W-1:0] meas,
		input logic signed [DATA_W-1:0] setp,
		input logic                     clr
	);
		longint e, e1, e2, gp, gi, gd, lim, isum, acc, res;
		if (clr) begin
			err_last  = '0;
			err_prev  = '0;
			integ_sum = '0;
		end
		e  = longint'(setp) - longint'(meas);
		e1 = longint'(err_last);
		e2 = longint'(err_prev);
		gp = longint'(pid_regs.kp);
		gi = longint'(pid_regs.ki);
		gd = longint'(pid_regs.kd);
		if (pid_regs.mode == MODE_POSITIONAL) begin
			lim  = longint'(pid_regs.limit) <<< FRAC_BITS;
			isum = longint'(integ_sum) + gi * e;
			if (isum >= lim)
				isum = lim;
			else if (isum <= -lim)
				isum = -lim;
			integ_sum = isum[33:0];
			acc = gp * e + isum + gd * (e - e1);
		end else begin
			acc = gp * (e - e1) + gi * e + gd * (e - 2 * e1 + e2);
		end
		err_prev = err_last;
		err_last = e[DATA_W:0];
		// signed divide truncates toward zero
		res = acc / (longint'(1) <<< FRAC_BITS);
		if (res > OUT_MAX)
			res = OUT_MAX;
		else if (res < OUT_MIN)
			res = OUT_MIN;
		return res[OUT_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_sample();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(19))
			0: v = {1'b1, {(DATA_W-1){1'b0}}};
			1: v = {1'b0, {(DATA_W-1){1'b1}}};
			2, 3, 4, 5, 6, 7, 8: v = DATA_W'(int'($urandom_range(1024)) - 512);
			default: v = DATA_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		logic [CFG_DATA_W-1:0] r;
		r = CFG_DATA_W'($urandom);
		case ($urandom_range(5))
			0: r[GAIN_W-1:0] = '0;
			1: r[GAIN_W-1:0] = '1;
			2, 3: r[GAIN_W-1:0] = GAIN_W'($urandom_range(512));
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		logic [CFG_DATA_W-1:0] r;
		case ($urandom_range(4))
			0: r = '0;
			1: r = '1;
			2, 3: r = CFG_DATA_W'($urandom_range(2000));
			default: r = CFG_DATA_W'($urandom);
		endcase
		return r;
	endfunction

	// result checker and sink-side stalls
	always @(posedge clk) begin : rx_check
		logic signed [OUT_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_ctrl.size() == 0) begin
				$display("%0t: unexpected control_out beat, expected none, got %0d",
					$time, control_out);
				errors++;
			end else begin
				want = expected_ctrl.pop_front();
				outstanding--;
				if (control_out !== want) begin
					$display("%0t: control_out mismatch, expected %0d, got %0d",
						$time, want, control_out);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_sample(
		input logic signed [DATA_W-1:0] meas,
		input logic signed [DATA_W-1:0] setp,
		input logic                     clr
	);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		measured <= meas;
		setpoint <= setp;
		clear    <= clr;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_ctrl.push_back(pid_output(meas, setp, clr));
		outstanding++;
	endtask

	// let every outstanding beat come back, then allow the pipeline to settle
	task automatic drain();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE:  pid_regs.mode  = data[0];
			REG_KP:    pid_regs.kp    = data[GAIN_W-1:0];
			REG_KI:    pid_regs.ki    = data[GAIN_W-1:0];
			REG_KD:    pid_regs.kd    = data[GAIN_W-1:0];
			REG_LIMIT: pid_regs.limit = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
			input logic [GAIN_W-1:0] d);
		write_reg(REG_KP, CFG_DATA_W'(p));
		write_reg(REG_KI, CFG_DATA_W'(i));
		write_reg(REG_KD, CFG_DATA_W'(d));
	endtask

	task automatic test_reset_defaults();
		send_sample(16'sd0, 16'sd0, 1'b1);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(16'sd100, 16'sd100, 1'b1);
	endtask

	task automatic test_positional_clamp();
		drain();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_POSITIONAL));
		set_gains('1, '1, '1);
		write_reg(REG_LIMIT, CFG_DATA_W'(1));
		send_sample(16'sd0, 16'sd1000, 1'b0);
		send_sample(16'sd1000, 16'sd0, 1'b0);
		send_sample(16'sd0, 16'sd1, 1'b1);
		// zero limit pins the integral at zero
		drain();
		write_reg(REG_LIMIT, '0);
		send_sample(16'sd5, -16'sd3, 1'b0);
		send_sample(-16'sd3, 16'sd5, 1'b0);
		drain();
		write_reg(REG_LIMIT, '1);
		send_sample(-16'sd32768, 16'sd32767, 1'b1);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
	endtask

	task automatic test_incremental();
		drain();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_INCREMENTAL));
		send_sample(16'sd0, 16'sd0, 1'b1);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		send_sample(16'sd32767, -16'sd32768, 1'b0);
		send_sample(-16'sd32768, 16'sd32767, 1'b0);
		drain();
		set_gains('0, '0, '0);
		send_sample(16'sd1234, -16'sd4321, 1'b0);
	endtask

	// a negative fraction must round toward zero, not down
	task automatic test_truncation();
		drain();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_POSITIONAL));
		set_gains(16'd1, '0, '0);
		send_sample(16'sd1, 16'sd0, 1'b1);
		send_sample(16'sd0, 16'sd300, 1'b0);
	endtask

	task automatic test_register_masking();
		drain();
		write_reg(REG_MODE, {{(CFG_DATA_W-1){1'b1}}, MODE_POSITIONAL});
		write_reg(REG_KP, 24'hA50180);
		write_reg(REG_KI, 24'hFF0040);
		write_reg(REG_KD, 24'h3C0200);
		write_reg(REG_LIMIT, 24'd50);
		for (int idx = REG_LIMIT + 1; idx < 2 ** CFG_IDX_W; idx++)
			write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
		send_sample(16'sd10, 16'sd200, 1'b0);
		send_sample(16'sd20, 16'sd180, 1'b0);
		send_sample(-16'sd700, 16'sd90, 1'b0);
	endtask

	task automatic randomize_settings();
		write_reg(REG_MODE, CFG_DATA_W'($urandom));
		write_reg(REG_KP, pick_gain());
		write_reg(REG_KI, pick_gain());
		write_reg(REG_KD, pick_gain());
		write_reg(REG_LIMIT, pick_limit());
	endtask

	// mostly a held setpoint with a moving measurement, now and then a new target or a clear
	task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % SETTINGS_EVERY == 0) begin
				drain();
				randomize_settings();
			end
			if ($urandom_range(4) == 0)
				target = pick_sample();
			send_sample(pick_sample(), target, $urandom_range(19) == 0);
		end
	endtask

	initial begin
		pid_regs  = '{mode: MODE_POSITIONAL, kp: KP_RST, ki: KI_RST, kd: KD_RST,
			limit: LIMIT_RST};
		err_last  = '0;
		err_prev  = '0;
		integ_sum = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct  = 17;
		sink_idle_pct = 58;
		test_reset_defaults();
		test_positional_clamp();
		test_incremental();
		test_truncation();
		test_register_masking();
		test_random(133, 17, 58);
		test_random(133, 58, 17);
		test_random(134, 0, 0);
		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hdl/pidpi_pkg.sv
hdl/pidpi_calc.sv
hdl/pid_position_incremental_core.sv
dv/tb_pid_position_incremental_core.sv
